// ----- design/length_prefixed_frame_parser_core_macros.svh -----
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define LPFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfp: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define LPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfp: next-cycle check failed");

`endif

// ----- design/lpfp_pkg.sv -----
package lpfp_pkg;

  // Sync header, sent low byte first
  localparam logic [7:0] HdrFirst  = 8'hFF;
  localparam logic [7:0] HdrSecond = 8'hFE;

  // Body length counts the command word and the checksum word
  localparam int unsigned BodyOverhead = 4;

  // Parser phase codes
  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhCmd  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhSum  = 3'd4;

  typedef logic [1:0] kind_t;

  // Result kinds
  localparam kind_t KindPayload = 2'd0;
  localparam kind_t KindEnd     = 2'd1;
  localparam kind_t KindBad     = 2'd2;

endpackage

// ----- design/lpfp_if.sv -----
// Received byte channel
interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parser result channel
interface lpfp_out_if;
  logic          valid;
  logic          ready;
  lpfp_pkg::kind_t kind;
  logic [15:0]   command;
  logic [7:0]    payload_byte;
  logic [15:0]   frame_checksum;

  modport source (output valid, output kind, output command, output payload_byte,
                  output frame_checksum, input ready);
  modport sink   (input valid, input kind, input command, input payload_byte,
                  input frame_checksum, output ready);
endinterface

// ----- design/length_prefixed_frame_parser_core.sv -----
// Length-prefixed frame parser. Takes one received byte per cycle unless the
// result side stalls it, and gives at most one result per byte: the byte is
// captured in the input register, then the parse step loads the result
// register when it advances. It hunts for the header FF FE,
// reads a little-endian body length
// of LENGTH_BITS bits (ceil(LENGTH_BITS/8) bytes), a little-endian command
// word, length-4 payload bytes (each emitted as kind 0 with the command) and
// a little-endian checksum word (emitted as kind 1, not verified). A length
// below 4 gives kind 2 and hunting resumes. Backpressure on the result side
// stalls the input only when a byte that produces a result meets a full
// result register.
module length_prefixed_frame_parser_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpfp_in_if.sink    rx_i,
  lpfp_out_if.source res_o
);
  import lpfp_pkg::*;

  localparam int unsigned LenBytes = (LENGTH_BITS + 7) / 8;
  localparam int unsigned LenW     = LenBytes * 8;

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Parser state
  logic [2:0]      phase_q, phase_d;
  logic [7:0]      prev_byte_q, prev_byte_d;
  logic            prev_vld_q, prev_vld_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [15:0]     cmd_q, cmd_d;
  logic [7:0]      cs_lo_q, cs_lo_d;

  // Result register
  logic        out_vld_q;
  kind_t       out_kind_q, res_kind;
  logic [15:0] out_cmd_q, res_cmd;
  logic [7:0]  out_pb_q, res_pb;
  logic [15:0] out_cs_q, res_cs;
  logic        res_has;

  logic            advance;
  logic [LenW-1:0] len_asm;
  logic [LENGTH_BITS-1:0] len_val;
  logic            len_last;

  // Assemble the length field, clearing it on its first byte
  always_comb begin
    for (int i = 0; i < LenBytes; i++) begin
      if (cnt_q == 2'(i)) begin
        len_asm[8*i +: 8] = in_byte_q;
      end else if (cnt_q == 2'd0) begin
        len_asm[8*i +: 8] = 8'd0;
      end else begin
        len_asm[8*i +: 8] = rem_q[8*i +: 8];
      end
    end
  end

  assign len_val  = len_asm[LENGTH_BITS-1:0];
  assign len_last = ({1'b0, cnt_q} + 3'd1) >= 3'(LenBytes);

  // Parse step for the byte in the input register
  always_comb begin
    phase_d     = phase_q;
    prev_byte_d = prev_byte_q;
    prev_vld_d  = prev_vld_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    cmd_d       = cmd_q;
    cs_lo_d     = cs_lo_q;
    res_has     = 1'b0;
    res_kind    = KindPayload;
    res_cmd     = 16'd0;
    res_pb      = 8'd0;
    res_cs      = 16'd0;
    unique case (phase_q)
      PhLen: begin
        rem_d = len_asm;
        if (len_last) begin
          cnt_d = 2'd0;
          if (len_val < LENGTH_BITS'(BodyOverhead)) begin
            rem_d       = '0;
            phase_d     = PhHunt;
            prev_vld_d  = 1'b0;
            prev_byte_d = 8'd0;
            res_has     = 1'b1;
            res_kind    = KindBad;
          end else begin
            rem_d   = LenW'(len_val - LENGTH_BITS'(BodyOverhead));
            phase_d = PhCmd;
          end
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      PhCmd: begin
        if (cnt_q == 2'd0) begin
          cmd_d = {8'd0, in_byte_q};
          cnt_d = 2'd1;
        end else begin
          cmd_d   = {in_byte_q, cmd_q[7:0]};
          cnt_d   = 2'd0;
          phase_d = (rem_q == '0) ? PhSum : PhData;
        end
      end
      PhData: begin
        rem_d = rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          phase_d = PhSum;
        end
        res_has  = 1'b1;
        res_kind = KindPayload;
        res_cmd  = cmd_q;
        res_pb   = in_byte_q;
      end
      PhSum: begin
        if (cnt_q == 2'd0) begin
          cs_lo_d = in_byte_q;
          cnt_d   = 2'd1;
        end else begin
          phase_d     = PhHunt;
          prev_vld_d  = 1'b0;
          prev_byte_d = 8'd0;
          cnt_d       = 2'd0;
          res_has     = 1'b1;
          res_kind    = KindEnd;
          res_cmd     = cmd_q;
          res_cs      = {in_byte_q, cs_lo_q};
        end
      end
      default: begin
        // Hunt, also for unused phase codes
        if (prev_vld_q && prev_byte_q == HdrFirst && in_byte_q == HdrSecond) begin
          prev_vld_d  = 1'b0;
          prev_byte_d = 8'd0;
          cnt_d       = 2'd0;
          rem_d       = '0;
          phase_d     = PhLen;
        end else begin
          phase_d     = PhHunt;
          prev_byte_d = in_byte_q;
          prev_vld_d  = 1'b1;
        end
      end
    endcase
  end

  // Advance unless a result meets a full, stalled result register
  assign advance    = in_vld_q && (!res_has || !out_vld_q || res_o.ready);
  assign rx_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Parser state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      prev_byte_q <= 8'd0;
      prev_vld_q  <= 1'b0;
      cnt_q       <= 2'd0;
      rem_q       <= '0;
      cmd_q       <= 16'd0;
      cs_lo_q     <= 8'd0;
    end else if (advance) begin
      phase_q     <= phase_d;
      prev_byte_q <= prev_byte_d;
      prev_vld_q  <= prev_vld_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      cmd_q       <= cmd_d;
      cs_lo_q     <= cs_lo_d;
    end
  end

  // Result register: load on a new result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_has) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_has) begin
      out_kind_q <= res_kind;
      out_cmd_q  <= res_cmd;
      out_pb_q   <= res_pb;
      out_cs_q   <= res_cs;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.kind           = out_kind_q;
  assign res_o.command        = out_cmd_q;
  assign res_o.payload_byte   = out_pb_q;
  assign res_o.frame_checksum = out_cs_q;

`include "length_prefixed_frame_parser_core_macros.svh"

  `LPFP_ASSERT_SAME(a_data_has_bytes, clk_i, rst_ni, phase_q == PhData, rem_q != '0)
  `LPFP_ASSERT_SAME(a_word_count, clk_i, rst_ni, phase_q == PhCmd || phase_q == PhSum, !cnt_q[1])
  `LPFP_ASSERT_SAME(a_pb_clean, clk_i, rst_ni, out_vld_q && (out_kind_q != KindPayload), out_pb_q == 8'd0)
  `LPFP_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, advance && res_has, out_vld_q)

endmodule
